[rtl/khm_pkg.sv]
package khm_pkg;

  localparam int NUM_BUCKETS = 256;
  localparam int WAYS        = 4;

  localparam int OP_W   = 2;
  localparam int KEY_W  = 32;
  localparam int VAL_W  = 32;
  localparam int ST_W   = 3;
  localparam int CFG_W  = 9;
  localparam int HASH_W = 12;

  localparam int BKT_W  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int EFF_W  = $clog2(NUM_BUCKETS + 1);
  localparam int WIDE_W = (CFG_W > EFF_W) ? CFG_W : EFF_W;
  localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int SLOT_W = 1 + KEY_W + VAL_W;
  localparam int ROW_W  = WAYS * SLOT_W;

  // Bit counter of the remainder unit.
  localparam int DIV_CNT_W = $clog2(HASH_W);

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(256);

  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

  localparam logic [ST_W-1:0] ST_NEW      = 3'd0;
  localparam logic [ST_W-1:0] ST_REPLACED = 3'd1;
  localparam logic [ST_W-1:0] ST_HIT      = 3'd2;
  localparam logic [ST_W-1:0] ST_MISS     = 3'd3;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd4;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } slot_t;

  typedef slot_t [WAYS-1:0] row_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [VAL_W-1:0] value;
  } result_t;

  // Byte fold: first byte ends up shifted by four, last byte by one.
  function automatic logic [HASH_W-1:0] fold_hash(input logic [KEY_W-1:0] key);
    logic [HASH_W-1:0] h;
    h = ({4'b0, key[31:24]} << 4) ^ ({4'b0, key[23:16]} << 3) ^
        ({4'b0, key[15:8]} << 2) ^ ({4'b0, key[7:0]} << 1);
    return h;
  endfunction

  // Zero counts as one bucket; anything above the table size saturates.
  function automatic logic [EFF_W-1:0] eff_buckets(input logic [CFG_W-1:0] c);
    logic [WIDE_W-1:0] cw;
    logic [WIDE_W-1:0] lim;
    logic [EFF_W-1:0]  e;
    cw  = WIDE_W'(c);
    lim = WIDE_W'(NUM_BUCKETS);
    if (c == '0) begin
      e = EFF_W'(1);
    end else if (cw > lim) begin
      e = EFF_W'(NUM_BUCKETS);
    end else begin
      e = EFF_W'(cw);
    end
    return e;
  endfunction

endpackage

[rtl/khm_if.sv]
interface khm_req_if;
  logic                      valid;
  logic                      ready;
  logic [khm_pkg::OP_W-1:0]  operation;
  logic [khm_pkg::KEY_W-1:0] key;
  logic [khm_pkg::VAL_W-1:0] value_in;
  modport source (output valid, output operation, output key, output value_in,
                  input ready);
  modport sink (input valid, input operation, input key, input value_in,
                output ready);
endinterface

interface khm_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [khm_pkg::ST_W-1:0]  status;
  logic [khm_pkg::VAL_W-1:0] value_out;
  modport source (output valid, output status, output value_out, input ready);
  modport sink (input valid, input status, input value_out, output ready);
endinterface

interface khm_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [khm_pkg::CFG_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/khm_ram.sv]
module khm_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [W-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [W-1:0]                           rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/khm_mod.sv]
// Restoring remainder unit, one hash bit per cycle.
module khm_mod (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [khm_pkg::HASH_W-1:0]  dividend,
  input  logic [khm_pkg::EFF_W-1:0]   divisor,
  output logic                        done,
  output logic [khm_pkg::BKT_W-1:0]   remainder
);

  logic                          run;
  logic [khm_pkg::DIV_CNT_W-1:0] cnt;
  logic [khm_pkg::EFF_W-1:0]     rem;
  logic [khm_pkg::EFF_W-1:0]     div;
  logic [khm_pkg::HASH_W-1:0]    dsh;
  logic [khm_pkg::EFF_W:0]       trial;
  logic [khm_pkg::EFF_W:0]       dext;

  assign trial = {rem, dsh[khm_pkg::HASH_W-1]};
  assign dext  = {1'b0, div};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= khm_pkg::DIV_CNT_W'(khm_pkg::HASH_W - 1);
      end else if (run) begin
        if (cnt == '0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dsh <= dividend;
      div <= divisor;
    end else if (run) begin
      dsh <= dsh << 1;
      if (trial >= dext) begin
        rem <= khm_pkg::EFF_W'(trial - dext);
      end else begin
        rem <= khm_pkg::EFF_W'(trial);
      end
    end
  end

  assign remainder = khm_pkg::BKT_W'(rem);

endmodule

[rtl/khm_bucket.sv]
// Bucket update: match/free search over the ways and the new row image.
module khm_bucket (
  input  khm_pkg::row_t              row,
  input  logic [khm_pkg::OP_W-1:0]   operation,
  input  logic [khm_pkg::KEY_W-1:0]  key,
  input  logic [khm_pkg::VAL_W-1:0]  value_in,
  output khm_pkg::row_t              row_next,
  output logic                       wr,
  output khm_pkg::result_t           res
);

  logic                      found;
  logic                      free;
  logic [khm_pkg::WAY_W-1:0] fidx;
  logic [khm_pkg::WAY_W-1:0] free_idx;

  // Walk down so the lowest way wins.
  always_comb begin
    found    = 1'b0;
    free     = 1'b0;
    fidx     = '0;
    free_idx = '0;
    for (int w = khm_pkg::WAYS - 1; w >= 0; w--) begin
      if (row[w].valid) begin
        if (row[w].key == key) begin
          found = 1'b1;
          fidx  = khm_pkg::WAY_W'(w);
        end
      end else begin
        free     = 1'b1;
        free_idx = khm_pkg::WAY_W'(w);
      end
    end
  end

  always_comb begin
    row_next   = row;
    wr         = 1'b0;
    res.status = khm_pkg::ST_MISS;
    res.value  = '0;
    case (operation)
      khm_pkg::OP_INSERT: begin
        if (found) begin
          res.status           = khm_pkg::ST_REPLACED;
          res.value            = row[fidx].value;
          row_next[fidx].value = value_in;
          wr                   = 1'b1;
        end else if (free) begin
          row_next[free_idx].valid = 1'b1;
          row_next[free_idx].key   = key;
          row_next[free_idx].value = value_in;
          res.status               = khm_pkg::ST_NEW;
          res.value                = value_in;
          wr                       = 1'b1;
        end else begin
          res.status = khm_pkg::ST_FULL;
        end
      end
      khm_pkg::OP_DELETE: begin
        if (found) begin
          res.status           = khm_pkg::ST_HIT;
          res.value            = row[fidx].value;
          row_next[fidx].valid = 1'b0;
          wr                   = 1'b1;
        end
      end
      default: begin
        // lookup, and the spare code behaves the same
        if (found) begin
          res.status = khm_pkg::ST_HIT;
          res.value  = row[fidx].value;
        end
      end
    endcase
  end

endmodule

[rtl/keyed_hash_map_top.sv]
// Channel | Dir  | Payload                          | Transfer when
// req     | in   | operation, key, value_in         | req.valid & req.ready
// rsp     | out  | status, value_out                | rsp.valid & rsp.ready
// cfg     | in   | data (bucket_count)              | cfg.valid & cfg.ready
//
// One item at a time, from req transfer to rsp valid: the bit-serial
// remainder unit, one handoff, one row read, one update/write-back.
// After reset a clearing pass zeroes every bucket row with req.ready low;
// cfg is always ready.
// rsp is a holding register: the next item is taken while a result waits,
// and its write-back stalls until that result transfers.
module keyed_hash_map_top (
  input  logic       clk,
  input  logic       rst,
  khm_req_if.sink    req,
  khm_rsp_if.source  rsp,
  khm_cfg_if.sink    cfg
);

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_DIV    = 6'b000100,
    S_READ   = 6'b001000,
    S_UPDATE = 6'b010000,
    S_SPARE  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  logic [khm_pkg::CFG_W-1:0] bucket_count;

  // Latched request.
  logic [khm_pkg::OP_W-1:0]  op;
  logic [khm_pkg::KEY_W-1:0] key;
  logic [khm_pkg::VAL_W-1:0] value;
  logic [khm_pkg::BKT_W-1:0] bucket;
  logic [khm_pkg::BKT_W-1:0] clr_cnt;

  // Result holding register.
  logic                      out_valid;
  logic [khm_pkg::ST_W-1:0]  out_status;
  logic [khm_pkg::VAL_W-1:0] out_value;

  logic                      accept;
  logic                      div_done;
  logic [khm_pkg::BKT_W-1:0] div_rem;
  logic                      out_free;
  logic                      commit;

  logic                       ram_we;
  logic [khm_pkg::BKT_W-1:0]  ram_waddr;
  logic [khm_pkg::ROW_W-1:0]  ram_wdata;
  logic [khm_pkg::ROW_W-1:0]  ram_rdata;

  khm_pkg::row_t    row_cur;
  khm_pkg::row_t    row_next;
  logic             row_wr;
  khm_pkg::result_t res;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid & req.ready;
  assign cfg.ready = 1'b1;
  assign out_free  = ~out_valid | rsp.ready;
  assign commit    = (state == S_UPDATE) & out_free;

  assign rsp.valid     = out_valid;
  assign rsp.status    = out_status;
  assign rsp.value_out = out_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count <= khm_pkg::CFG_RESET;
    end else if (cfg.valid & cfg.ready) begin
      bucket_count <= cfg.data;
    end
  end

  khm_mod u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (accept),
    .dividend  (khm_pkg::fold_hash(req.key)),
    .divisor   (khm_pkg::eff_buckets(bucket_count)),
    .done      (div_done),
    .remainder (div_rem)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_cnt == khm_pkg::BKT_W'(khm_pkg::NUM_BUCKETS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_next = S_READ;
        end
      end
      S_READ:   state_next = S_UPDATE;
      S_UPDATE: begin
        if (commit) begin
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (commit) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op    <= req.operation;
      key   <= req.key;
      value <= req.value_in;
    end
    if ((state == S_DIV) && div_done) begin
      bucket <= div_rem;
    end
    if (commit) begin
      out_status <= res.status;
      out_value  <= res.value;
    end
  end

  // Row read is continuous at the latched bucket; data is stable while the
  // update stalls because nothing writes in between.
  assign row_cur = khm_pkg::row_t'(ram_rdata);

  khm_bucket u_bucket (
    .row       (row_cur),
    .operation (op),
    .key       (key),
    .value_in  (value),
    .row_next  (row_next),
    .wr        (row_wr),
    .res       (res)
  );

  always_comb begin
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt;
      ram_wdata = '0;
    end else begin
      ram_we    = commit & row_wr;
      ram_waddr = bucket;
      ram_wdata = khm_pkg::ROW_W'(row_next);
    end
  end

  khm_ram #(
    .W     (khm_pkg::ROW_W),
    .DEPTH (khm_pkg::NUM_BUCKETS)
  ) u_rows (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (bucket),
    .rdata (ram_rdata)
  );

endmodule
